// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ple_pkg.sv -----
// Package for the positional list engine: operation and status codes, field widths.
package ple_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_DW   = 40;
  localparam int unsigned OUT_DW  = 40;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

endpackage

// ----- hdl/positional_list_engine_core.sv -----
// Positional list engine: bounded ordered list with insert, remove and display.
//
//   Channel | Dir | Handshake          | Payload
//   in_     | in  | in_tvalid/tready   | tdata: operation, value, position
//   out_    | out | out_tvalid/tready  | tdata: element, status; tlast: last
//
// Insert and remove move one cell at a time, through a read state and then a write
// state (separate read and write ports). Display reads each element and then emits
// it. Errors and the empty-list insert go straight to the response.
// Synchronous active-low reset clears the count; store cells are unset until written.
// in_tready is high only while the sequencer is idle; a stalled out_tready
// holds the sequencer at its next emit.

`include "assert_macros.svh"

module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [1:0] operation, [33:2] value, [39:34] position
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [31:0] element, [33:32] status, [39:34] zero
  output logic              out_tlast
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CMW = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DSP_RD,
    S_DSP_OUT,
    S_RESP
  } state_t;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      tgt_r, tgt_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_elem_r, out_elem_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [VALUE_W-1:0] mem_wd;

  logic [OP_W-1:0]    in_op;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  logic [CMW-1:0]     pos_c, cnt_c;
  logic               out_free;

  assign in_op    = in_tdata[OP_W-1:0];
  assign in_value = in_tdata[OP_W+VALUE_W-1:OP_W];
  assign in_pos   = in_tdata[OP_W+VALUE_W+POS_W-1:OP_W+VALUE_W];
  assign pos_c    = CMW'(in_pos);
  assign cnt_c    = CMW'(count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-VALUE_W-STAT_W){1'b0}}, out_stat_r, out_elem_r};
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt  = out_elem_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = tgt_r;
    mem_wd        = val_r;
    mem_ra        = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_INSERT: begin
              state_nxt = S_RESP;
              if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_wa    = '0;
                mem_wd    = in_value;
                count_nxt = CW'(1);
                stat_nxt  = ST_OK;
              end else if (cnt_c == CMW'(CAPACITY)) begin
                stat_nxt = ST_FULL;
              end else if (in_pos == '0 || pos_c > cnt_c + CMW'(1)) begin
                stat_nxt = ST_BADPOS;
              end else begin
                idx_nxt   = count_r;
                tgt_nxt   = AW'(in_pos - POS_W'(1));
                val_nxt   = in_value;
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              state_nxt = S_RESP;
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (in_pos == '0 || pos_c > cnt_c) begin
                stat_nxt = ST_BADPOS;
              end else begin
                idx_nxt   = CW'(in_pos - POS_W'(1));
                state_nxt = S_REM_RD;
              end
            end
            OP_DISPLAY: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DSP_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        // Move cells up from the tail until the target cell is free.
        if (idx_r > CW'(tgt_r)) begin
          mem_ra    = AW'(idx_r - CW'(1));
          state_nxt = S_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = tgt_r;
          mem_wd    = val_r;
          count_nxt = count_r + CW'(1);
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = rd_data_r;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_INS_RD;
      end
      S_REM_RD: begin
        if (CMW'(idx_r) + CMW'(1) < cnt_c) begin
          mem_ra    = AW'(idx_r + CW'(1));
          state_nxt = S_REM_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = rd_data_r;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_REM_RD;
      end
      S_DSP_RD: begin
        mem_ra    = idx_r[AW-1:0];
        state_nxt = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = rd_data_r;
          out_stat_nxt  = ST_OK;
          out_last_nxt  = (idx_r + CW'(1) == count_r);
          idx_nxt       = idx_r + CW'(1);
          state_nxt     = (idx_r + CW'(1) == count_r) ? S_IDLE : S_DSP_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = '0;
          out_stat_nxt  = stat_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    tgt_r      <= tgt_nxt;
    val_r      <= val_nxt;
    stat_r     <= stat_nxt;
    out_elem_r <= out_elem_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, CMW'(count_r) <= CMW'(CAPACITY),
                 "count over capacity")
  `ASSERT_IMPLY(a_err_is_last, clk, rst_n, out_valid_r && out_stat_r != ST_OK, out_last_r,
                "status result without last")
  `ASSERT_IMPLY(a_count_step, clk, rst_n, count_r != $past(count_r),
                count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1),
                "count moved by more than one")
  `ASSERT_IMPLY(a_busy_no_ready, clk, rst_n, state_r == S_DSP_OUT && !out_free,
                $stable(idx_r) || $past(state_r) != S_DSP_OUT,
                "display index moved while stalled")

endmodule
